>>> rtl/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// shared constants, state encoding and control/status bundles
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int MOD_WIDTH_DEF = 32;
    localparam int EXP_WIDTH_DEF = 63;
    localparam int BASE_WIDTH    = 63;

    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL_R,
        ST_WB_R,
        ST_MUL_B,
        ST_WB_B,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic reduce_step;
        logic start_r;
        logic start_b;
        logic mul_step;
        logic store_r;
        logic store_b;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic e_zero;
        logic e_lsb;
        logic e_rest_zero;
        logic out_busy;
    } status_t;

endpackage

>>> rtl/modular_exponentiation_top.sv
`timescale 1ns / 1ps
// sequence: base reduction, then per exponent bit a check state, a multiply when
//   the bit is set and a square (skipped after the top set bit), then the output load
// throughput: one item at a time, set by the single bit-serial modular multiplier
// reset: rst_n asynchronous active low, modulus returns to 1000000007, output empty
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// base^exponent mod modulus by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // slave side: base_value, exponent
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [((mexp_pkg::BASE_WIDTH+EXP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // master side: power_result
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [((MOD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // modulus write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [MOD_WIDTH-1:0] cfg_data
);

    localparam int BW    = mexp_pkg::BASE_WIDTH;
    localparam int OUT_W = ((MOD_WIDTH + 7) / 8) * 8;

    mexp_pkg::cmd_t       cmd;
    mexp_pkg::status_t    status;
    logic [MOD_WIDTH-1:0] result;

    assign cfg_ready = 1'b1;

    mexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mexp_dp #(
        .MOD_WIDTH (MOD_WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_value (cfg_data),
        .base_in   (s_axis_tdata[BW-1:0]),
        .exp_in    (s_axis_tdata[BW+EXP_WIDTH-1:BW]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (result)
    );

    assign m_axis_tdata = OUT_W'(result);

endmodule

>>> rtl/mexp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer for base reduction and square-and-multiply over the exponent
// ----------------------------------------------------------------------------
module mexp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mexp_pkg::status_t status,
    output mexp_pkg::cmd_t    cmd
);

    mexp_pkg::state_t state_reg;
    mexp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mexp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mexp_pkg::ST_REDUCE;
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                cmd.reduce_step = 1'b1;
                if (status.cnt_zero)
                begin
                    state_next = mexp_pkg::ST_CHECK;
                end
            end
            mexp_pkg::ST_CHECK:
            begin
                if (status.e_zero)
                begin
                    state_next = mexp_pkg::ST_FINISH;
                end
                else if (status.e_lsb)
                begin
                    cmd.start_r = 1'b1;
                    state_next  = mexp_pkg::ST_MUL_R;
                end
                else
                begin
                    cmd.start_b = 1'b1;
                    state_next  = mexp_pkg::ST_MUL_B;
                end
            end
            mexp_pkg::ST_MUL_R:
            begin
                cmd.mul_step = 1'b1;
                if (status.cnt_zero)
                begin
                    state_next = mexp_pkg::ST_WB_R;
                end
            end
            mexp_pkg::ST_WB_R:
            begin
                cmd.store_r = 1'b1;
                if (status.e_rest_zero)
                begin
                    state_next = mexp_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.start_b = 1'b1;
                    state_next  = mexp_pkg::ST_MUL_B;
                end
            end
            mexp_pkg::ST_MUL_B:
            begin
                cmd.mul_step = 1'b1;
                if (status.cnt_zero)
                begin
                    state_next = mexp_pkg::ST_WB_B;
                end
            end
            mexp_pkg::ST_WB_B:
            begin
                cmd.store_b = 1'b1;
                state_next  = mexp_pkg::ST_CHECK;
            end
            mexp_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/mexp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_dp
// modulus register, restoring reduction, bit-serial modular multiplier,
// exponent shifter and output register
// ----------------------------------------------------------------------------
module mexp_dp #(
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [MOD_WIDTH-1:0]            cfg_value,
    input  logic [mexp_pkg::BASE_WIDTH-1:0] base_in,
    input  logic [EXP_WIDTH-1:0]            exp_in,
    input  mexp_pkg::cmd_t                  cmd,
    output mexp_pkg::status_t               status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [MOD_WIDTH-1:0]            out_value
);

    localparam int BW    = mexp_pkg::BASE_WIDTH;
    localparam int STEPS = (BW > MOD_WIDTH) ? BW : MOD_WIDTH;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [MOD_WIDTH-1:0] MOD_RESET = mexp_pkg::MODULUS_RESET[MOD_WIDTH-1:0];

    logic [MOD_WIDTH-1:0] mod_reg, mod_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MOD_WIDTH-1:0] out_reg, out_next;
    logic [BW-1:0]        base_reg, base_next;
    logic [EXP_WIDTH-1:0] e_reg, e_next;
    logic [MOD_WIDTH-1:0] b_reg, b_next;
    logic [MOD_WIDTH-1:0] r_reg, r_next;
    logic [MOD_WIDTH-1:0] acc_reg, acc_next;
    logic [MOD_WIDTH-1:0] x_reg, x_next;
    logic [MOD_WIDTH-1:0] y_reg, y_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic [MOD_WIDTH-1:0] m_eff;
    logic [MOD_WIDTH:0]   red_t;
    logic [MOD_WIDTH:0]   red_m;
    logic [MOD_WIDTH-1:0] red_res;
    logic [MOD_WIDTH+1:0] mul_s;
    logic [MOD_WIDTH+1:0] mul_m1;
    logic [MOD_WIDTH+1:0] mul_m2;
    logic [MOD_WIDTH+1:0] mul_sel;

    assign m_eff = (mod_reg == '0) ? {{(MOD_WIDTH-1){1'b0}}, 1'b1} : mod_reg;

    // restoring reduction step, remainder stays below the modulus
    assign red_t   = {b_reg, base_reg[BW-1]};
    assign red_m   = {1'b0, m_eff};
    assign red_res = (red_t >= red_m) ? MOD_WIDTH'(red_t - red_m) : red_t[MOD_WIDTH-1:0];

    // interleaved multiply step: 2*acc + bit*x lies below three times the modulus
    assign mul_s  = {1'b0, acc_reg, 1'b0}
                  + (y_reg[MOD_WIDTH-1] ? {2'b00, x_reg} : '0);
    assign mul_m1 = {2'b00, m_eff};
    assign mul_m2 = {1'b0, m_eff, 1'b0};

    always_comb
    begin
        if (mul_s >= mul_m2)
        begin
            mul_sel = mul_s - mul_m2;
        end
        else if (mul_s >= mul_m1)
        begin
            mul_sel = mul_s - mul_m1;
        end
        else
        begin
            mul_sel = mul_s;
        end
    end

    always_comb
    begin
        mod_next       = cfg_we ? cfg_value : mod_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        base_next      = base_reg;
        e_next         = e_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cnt_next       = cnt_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = r_reg;
        end

        if (cmd.load)
        begin
            base_next = base_in;
            e_next    = exp_in;
            b_next    = '0;
            r_next    = {{(MOD_WIDTH-1){1'b0}}, 1'b1};
            cnt_next  = CNT_W'(BW - 1);
        end

        if (cmd.reduce_step)
        begin
            b_next    = red_res;
            base_next = base_reg << 1;
            cnt_next  = cnt_reg - 1'b1;
        end

        if (cmd.start_r || cmd.start_b)
        begin
            x_next   = cmd.start_r ? r_reg : b_reg;
            y_next   = b_reg;
            acc_next = '0;
            cnt_next = CNT_W'(MOD_WIDTH - 1);
        end

        if (cmd.mul_step)
        begin
            acc_next = mul_sel[MOD_WIDTH-1:0];
            y_next   = y_reg << 1;
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.store_r)
        begin
            r_next = acc_reg;
        end

        if (cmd.store_b)
        begin
            b_next = acc_reg;
            e_next = e_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg       <= MOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mod_reg       <= mod_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        base_reg <= base_next;
        e_reg    <= e_next;
        b_reg    <= b_next;
        r_reg    <= r_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        cnt_reg  <= cnt_next;
    end

    assign status.cnt_zero    = (cnt_reg == '0);
    assign status.e_zero      = (e_reg == '0);
    assign status.e_lsb       = e_reg[0];
    assign status.e_rest_zero = ((e_reg >> 1) == '0);
    assign status.out_busy    = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_value = out_reg;

endmodule
